// ----- rtl/core/magic_sector_bitmap_collector_defines.svh -----
// ----------------------------------------------------------------------------
// magic sector bitmap collector - assertion macros
// Shared concurrent assertion forms for the collector RTL.
// ----------------------------------------------------------------------------
`ifndef MAGIC_SECTOR_BITMAP_COLLECTOR_DEFINES_SVH
`define MAGIC_SECTOR_BITMAP_COLLECTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MSBC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MSBC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/msbc_pkg.sv -----
// ----------------------------------------------------------------------------
// msbc_pkg
// Types and constants shared by the magic sector bitmap collector modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msbc_pkg;

	// geometry
	localparam int DEVICE_SECTORS_DEF = 65536;
	localparam int SECTOR_BYTES       = 512;
	localparam int BEAT_BYTES         = 8;
	localparam int MAGIC_WORDS        = 64;
	localparam int MAGIC_BYTES        = MAGIC_WORDS * 8;
	localparam int SECTOR_W           = 16;
	localparam int CAP_W              = 17;
	localparam int CFG_W              = 17;
	localparam int MAGIC_LEN_W        = 10;
	localparam int COUNT_W            = 32;

	// mark store rows
	localparam int ROW_BITS = 32;
	localparam int ROW_LSB  = 5;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// config reset values
	localparam logic [MAGIC_LEN_W-1:0] MAGIC_LEN_RST = 10'd512;
	localparam logic [CAP_W-1:0]       CAPACITY_RST  = 17'd65536;

	typedef enum logic [0:0] {
		CFG_MAGIC_LEN = 1'b0,
		CFG_CAPACITY  = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_NEXT   = 2'd2,
		KIND_REWIND = 2'd3
	} kind_t;

	// work classes handed from front to back
	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_OOR    = 3'd1,
		OP_MARK   = 3'd2,
		OP_NEXT   = 3'd3,
		OP_REWIND = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		BK_CLEAR = 2'd0,
		BK_IDLE  = 2'd1,
		BK_MARK  = 2'd2,
		BK_SCAN  = 2'd3
	} back_state_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [SECTOR_W-1:0] sector;
		logic [5:0]          word_index;
		logic [63:0]         data;
		logic                last_beat;
	} in_item_t;

	typedef struct packed {
		logic                sector_marked;
		logic                already_marked;
		logic                out_of_range;
		logic [SECTOR_W-1:0] range_start;
		logic [CAP_W-1:0]    range_length;
		logic                range_found;
		logic [COUNT_W-1:0]  collected_count;
		logic [COUNT_W-1:0]  already_count;
	} out_item_t;

	typedef struct packed {
		op_t                 op;
		logic [SECTOR_W-1:0] sector;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- rtl/core/msbc_front.sv -----
// ----------------------------------------------------------------------------
// msbc_front
// Accepts items, holds the magic pattern, compares data beats against it and
// classifies every item into a work entry for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msbc_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  msbc_pkg::in_item_t                    item,
	input  logic [msbc_pkg::MAGIC_LEN_W-1:0]      magic_len,
	input  logic [msbc_pkg::CAP_W-1:0]            cap,
	input  logic                                  clearing,
	input  msbc_pkg::q_status_t                   q_status,
	output logic                                  push,
	output msbc_pkg::q_entry_t                    push_entry
);

	localparam int LIMIT_MAX = (msbc_pkg::SECTOR_BYTES < msbc_pkg::MAGIC_BYTES) ?
		msbc_pkg::SECTOR_BYTES : msbc_pkg::MAGIC_BYTES;
	localparam logic [msbc_pkg::MAGIC_LEN_W-1:0] LIMIT_V = msbc_pkg::MAGIC_LEN_W'(LIMIT_MAX);

	logic [63:0]        magic_mem [msbc_pkg::MAGIC_WORDS];
	logic               valid_s1;
	msbc_pkg::in_item_t item_s1;
	logic [63:0]        magic_s1;
	logic               match_q;
	logic               accept;
	logic [msbc_pkg::MAGIC_LEN_W-1:0] limit;
	logic [msbc_pkg::MAGIC_LEN_W-1:0] pos;
	logic               beat_ok;
	logic               beyond;

	// transfer handshake
	assign item_stall = clearing || (valid_s1 && q_status.full);
	assign accept     = item_valid && !item_stall;
	assign push       = valid_s1 && !q_status.full;

	// magic pattern store, word read on every transfer
	always_ff @(posedge clk) begin
		if (accept && item.kind == msbc_pkg::KIND_LOAD) begin
			magic_mem[item.word_index] <= item.data;
		end
		if (accept) begin
			magic_s1 <= magic_mem[item.word_index];
			item_s1  <= item;
		end
	end

	// stage valid and running match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			match_q  <= 1'b1;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
			if (push && item_s1.kind == msbc_pkg::KIND_DATA) begin
				match_q <= item_s1.last_beat ? 1'b1 : (match_q && beat_ok);
			end
		end
	end

	// byte compare against the pattern below the compare limit
	always_comb begin
		limit   = (magic_len > LIMIT_V) ? LIMIT_V : magic_len;
		beat_ok = 1'b1;
		pos     = '0;
		for (int k = 0; k < msbc_pkg::BEAT_BYTES; k++) begin
			pos = msbc_pkg::MAGIC_LEN_W'(item_s1.word_index) *
				msbc_pkg::MAGIC_LEN_W'(msbc_pkg::BEAT_BYTES) + msbc_pkg::MAGIC_LEN_W'(k);
			if (pos < limit && item_s1.data[8*k +: 8] != magic_s1[8*k +: 8]) begin
				beat_ok = 1'b0;
			end
		end
	end

	assign beyond = {1'b0, item_s1.sector} >= cap;

	// classify into back end work
	always_comb begin
		push_entry.sector = item_s1.sector;
		push_entry.op     = msbc_pkg::OP_NONE;
		unique case (item_s1.kind)
			msbc_pkg::KIND_LOAD: begin
				push_entry.op = msbc_pkg::OP_NONE;
			end
			msbc_pkg::KIND_DATA: begin
				if (!item_s1.last_beat) begin
					push_entry.op = msbc_pkg::OP_NONE;
				end else if (beyond) begin
					push_entry.op = msbc_pkg::OP_OOR;
				end else if (match_q && beat_ok) begin
					push_entry.op = msbc_pkg::OP_MARK;
				end else begin
					push_entry.op = msbc_pkg::OP_NONE;
				end
			end
			msbc_pkg::KIND_NEXT: begin
				push_entry.op = msbc_pkg::OP_NEXT;
			end
			msbc_pkg::KIND_REWIND: begin
				push_entry.op = msbc_pkg::OP_REWIND;
			end
			default: begin
				push_entry.op = msbc_pkg::OP_NONE;
			end
		endcase
	end

endmodule

// ----- rtl/core/msbc_queue.sv -----
// ----------------------------------------------------------------------------
// msbc_queue
// Short in-order queue of work entries between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msbc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  msbc_pkg::q_entry_t  push_entry,
	input  logic                pop,
	output msbc_pkg::q_entry_t  head,
	output msbc_pkg::q_status_t status
);

	localparam int PTR_W = $clog2(msbc_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(msbc_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_V = CNT_W'(msbc_pkg::QUEUE_DEPTH);

	msbc_pkg::q_entry_t entry_q [msbc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign status.full  = (count_q == DEPTH_V);
	assign status.empty = (count_q == '0);
	assign head         = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/msbc_back.sv -----
// ----------------------------------------------------------------------------
// msbc_back
// Owns the sector mark store and the counters: clears the store after reset,
// marks sectors, walks the store for range requests and drives results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "magic_sector_bitmap_collector_defines.svh"

module msbc_back #(
	parameter int DEVICE_SECTORS = msbc_pkg::DEVICE_SECTORS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [msbc_pkg::CAP_W-1:0]        cap,
	input  msbc_pkg::q_entry_t                head,
	input  msbc_pkg::q_status_t               q_status,
	output logic                              pop,
	output logic                              clearing,
	output logic                              result_valid,
	input  logic                              result_stall,
	output msbc_pkg::out_item_t               result
);

	localparam int SPAN         = 2 ** msbc_pkg::SECTOR_W;
	localparam int MARK_SECTORS = (DEVICE_SECTORS < SPAN) ? DEVICE_SECTORS : SPAN;
	localparam int ROWS         = (MARK_SECTORS + msbc_pkg::ROW_BITS - 1) / msbc_pkg::ROW_BITS;
	localparam int ROW_AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RIDX_W       = msbc_pkg::CAP_W - msbc_pkg::ROW_LSB;
	localparam int BIT_W        = msbc_pkg::ROW_LSB;
	localparam logic [RIDX_W-1:0] ROWS_V   = RIDX_W'(ROWS);
	localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);

	// mark store
	logic [msbc_pkg::ROW_BITS-1:0] mark_mem [ROWS];
	logic [msbc_pkg::ROW_BITS-1:0] rd_row_q;
	logic                          mem_we;
	logic [ROW_AW-1:0]             mem_waddr;
	logic [msbc_pkg::ROW_BITS-1:0] mem_wdata;
	logic                          mem_re;
	logic [ROW_AW-1:0]             mem_raddr;

	// control and working registers
	msbc_pkg::back_state_t          state_q, state_nxt;
	logic [ROW_AW-1:0]              clr_row_q, clr_row_nxt;
	logic [msbc_pkg::SECTOR_W-1:0]  work_sector_q, work_sector_nxt;
	logic [msbc_pkg::CAP_W-1:0]     pos_q, pos_nxt;
	logic [msbc_pkg::SECTOR_W-1:0]  start_q, start_nxt;
	logic                           in_run_q, in_run_nxt;
	logic [msbc_pkg::CAP_W-1:0]     scan_q, scan_nxt;
	logic [msbc_pkg::COUNT_W-1:0]   new_total_q, new_total_nxt;
	logic [msbc_pkg::COUNT_W-1:0]   repeat_total_q, repeat_total_nxt;
	logic                           result_valid_q;
	msbc_pkg::out_item_t            result_q;

	// combinational helpers
	logic                           out_free;
	logic                           emit;
	msbc_pkg::out_item_t            emit_item;
	logic [msbc_pkg::ROW_BITS-1:0]  row;
	logic [msbc_pkg::ROW_BITS-1:0]  below_cap;
	logic [msbc_pkg::ROW_BITS-1:0]  at_or_after;
	logic [msbc_pkg::ROW_BITS-1:0]  hunt;
	logic                           hit;
	logic [BIT_W-1:0]               hit_bit;
	logic [msbc_pkg::CAP_W-1:0]     hit_pos;
	logic [msbc_pkg::CAP_W:0]       next_base;
	logic                           next_done;
	logic [msbc_pkg::CAP_W-1:0]     run_end;
	logic                           run_done;

	assign out_free     = !result_valid_q || !result_stall;
	assign clearing     = (state_q == msbc_pkg::BK_CLEAR);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// mark store ports, read data registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mark_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_row_q <= mark_mem[mem_raddr];
		end
	end

	// row window for the range walk
	always_comb begin
		row = (pos_q[msbc_pkg::CAP_W-1:msbc_pkg::ROW_LSB] < ROWS_V) ? rd_row_q : '0;
		for (int j = 0; j < msbc_pkg::ROW_BITS; j++) begin
			at_or_after[j] = (BIT_W'(j) >= pos_q[BIT_W-1:0]);
			below_cap[j]   = (cap[msbc_pkg::CAP_W-1:msbc_pkg::ROW_LSB] !=
				pos_q[msbc_pkg::CAP_W-1:msbc_pkg::ROW_LSB]) || (BIT_W'(j) < cap[BIT_W-1:0]);
		end
		hunt = in_run_q ? ((~row | ~below_cap) & at_or_after) : (row & below_cap & at_or_after);
		hit     = |hunt;
		hit_bit = '0;
		for (int j = msbc_pkg::ROW_BITS - 1; j >= 0; j--) begin
			if (hunt[j]) begin
				hit_bit = BIT_W'(j);
			end
		end
		hit_pos   = {pos_q[msbc_pkg::CAP_W-1:msbc_pkg::ROW_LSB], hit_bit};
		next_base = {({1'b0, pos_q[msbc_pkg::CAP_W-1:msbc_pkg::ROW_LSB]} + (RIDX_W+1)'(1)),
			BIT_W'(0)};
		next_done = next_base >= {1'b0, cap};
	end

	// next state, store access and result
	always_comb begin
		state_nxt        = state_q;
		clr_row_nxt      = clr_row_q;
		work_sector_nxt  = work_sector_q;
		pos_nxt          = pos_q;
		start_nxt        = start_q;
		in_run_nxt       = in_run_q;
		scan_nxt         = scan_q;
		new_total_nxt    = new_total_q;
		repeat_total_nxt = repeat_total_q;
		pop              = 1'b0;
		emit             = 1'b0;
		mem_we           = 1'b0;
		mem_waddr        = clr_row_q;
		mem_wdata        = '0;
		mem_re           = 1'b0;
		mem_raddr        = pos_q[ROW_AW+msbc_pkg::ROW_LSB-1:msbc_pkg::ROW_LSB];
		run_end          = cap;
		run_done         = 1'b0;
		emit_item                 = '0;
		emit_item.collected_count = new_total_q;
		emit_item.already_count   = repeat_total_q;

		unique case (state_q)
			msbc_pkg::BK_CLEAR: begin
				mem_we      = 1'b1;
				mem_waddr   = clr_row_q;
				mem_wdata   = '0;
				clr_row_nxt = clr_row_q + ROW_AW'(1);
				if (clr_row_q == ROW_LAST) begin
					state_nxt = msbc_pkg::BK_IDLE;
				end
			end

			msbc_pkg::BK_IDLE: begin
				if (!q_status.empty) begin
					unique case (head.op)
						msbc_pkg::OP_NONE: begin
							if (out_free) begin
								emit = 1'b1;
								pop  = 1'b1;
							end
						end
						msbc_pkg::OP_OOR: begin
							if (out_free) begin
								emit                   = 1'b1;
								pop                    = 1'b1;
								emit_item.out_of_range = 1'b1;
							end
						end
						msbc_pkg::OP_REWIND: begin
							if (out_free) begin
								emit     = 1'b1;
								pop      = 1'b1;
								scan_nxt = '0;
							end
						end
						msbc_pkg::OP_MARK: begin
							pop             = 1'b1;
							mem_re          = 1'b1;
							mem_raddr       = head.sector[ROW_AW+msbc_pkg::ROW_LSB-1:
								msbc_pkg::ROW_LSB];
							work_sector_nxt = head.sector;
							state_nxt       = msbc_pkg::BK_MARK;
						end
						msbc_pkg::OP_NEXT: begin
							if (scan_q >= cap) begin
								// nothing left below the capacity
								if (out_free) begin
									emit = 1'b1;
									pop  = 1'b1;
								end
							end else begin
								pop        = 1'b1;
								pos_nxt    = scan_q;
								in_run_nxt = 1'b0;
								mem_re     = 1'b1;
								mem_raddr  = scan_q[ROW_AW+msbc_pkg::ROW_LSB-1:msbc_pkg::ROW_LSB];
								state_nxt  = msbc_pkg::BK_SCAN;
							end
						end
						default: begin
							if (out_free) begin
								emit = 1'b1;
								pop  = 1'b1;
							end
						end
					endcase
				end
			end

			msbc_pkg::BK_MARK: begin
				// read-modify-write of the sector's row
				if (out_free) begin
					emit      = 1'b1;
					state_nxt = msbc_pkg::BK_IDLE;
					if (rd_row_q[work_sector_q[BIT_W-1:0]]) begin
						emit_item.already_marked = 1'b1;
						if (repeat_total_q != '1) begin
							repeat_total_nxt = repeat_total_q + msbc_pkg::COUNT_W'(1);
						end
					end else begin
						emit_item.sector_marked = 1'b1;
						mem_we    = 1'b1;
						mem_waddr = work_sector_q[ROW_AW+msbc_pkg::ROW_LSB-1:msbc_pkg::ROW_LSB];
						mem_wdata = rd_row_q;
						mem_wdata[work_sector_q[BIT_W-1:0]] = 1'b1;
						if (new_total_q != '1) begin
							new_total_nxt = new_total_q + msbc_pkg::COUNT_W'(1);
						end
					end
					emit_item.collected_count = new_total_nxt;
					emit_item.already_count   = repeat_total_nxt;
				end
			end

			msbc_pkg::BK_SCAN: begin
				if (hit && !in_run_q) begin
					// run starts here, hunt for its end in the same row
					start_nxt  = hit_pos[msbc_pkg::SECTOR_W-1:0];
					pos_nxt    = hit_pos;
					in_run_nxt = 1'b1;
				end else if (hit) begin
					run_done = 1'b1;
					run_end  = hit_pos;
				end else if (next_done) begin
					run_done = 1'b1;
					run_end  = cap;
				end else begin
					pos_nxt   = next_base[msbc_pkg::CAP_W-1:0];
					mem_re    = 1'b1;
					mem_raddr = next_base[ROW_AW+msbc_pkg::ROW_LSB-1:msbc_pkg::ROW_LSB];
				end
				if (run_done && out_free) begin
					emit      = 1'b1;
					scan_nxt  = run_end;
					state_nxt = msbc_pkg::BK_IDLE;
					if (in_run_q) begin
						emit_item.range_found  = 1'b1;
						emit_item.range_start  = start_q;
						emit_item.range_length = run_end - {1'b0, start_q};
					end
				end
			end

			default: begin
				state_nxt = msbc_pkg::BK_IDLE;
			end
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= msbc_pkg::BK_CLEAR;
			clr_row_q      <= '0;
			in_run_q       <= 1'b0;
			scan_q         <= '0;
			new_total_q    <= '0;
			repeat_total_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_nxt;
			clr_row_q      <= clr_row_nxt;
			in_run_q       <= in_run_nxt;
			scan_q         <= scan_nxt;
			new_total_q    <= new_total_nxt;
			repeat_total_q <= repeat_total_nxt;
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		work_sector_q <= work_sector_nxt;
		pos_q         <= pos_nxt;
		start_q       <= start_nxt;
		if (emit) begin
			result_q <= emit_item;
		end
	end

	`MSBC_ASSERT_NOW(a_no_result_in_clear, clk, arst_n, state_q == msbc_pkg::BK_CLEAR, !emit, "result produced during clear pass")
	`MSBC_ASSERT_NOW(a_single_flag, clk, arst_n, emit, $onehot0({emit_item.sector_marked, emit_item.already_marked, emit_item.out_of_range, emit_item.range_found}), "more than one result flag set")
	`MSBC_ASSERT_NOW(a_run_nonempty, clk, arst_n, emit && emit_item.range_found, emit_item.range_length != '0, "reported run has zero length")
	`MSBC_ASSERT_NOW(a_walk_below_cap, clk, arst_n, state_q == msbc_pkg::BK_SCAN, pos_q < cap, "range walk position at or past capacity")
	`MSBC_ASSERT_NEXT(a_total_monotonic, clk, arst_n, 1'b1, new_total_q >= $past(new_total_q), "collected total went down")

endmodule

// ----- rtl/core/magic_sector_bitmap_collector.sv -----
// ----------------------------------------------------------------------------
// magic_sector_bitmap_collector
// Marks sectors whose leading bytes match a stored magic pattern and reports
// runs of marked sectors on request.
// ----------------------------------------------------------------------------
// After reset the block sweeps the mark store to zero, one 32-sector row per
// cycle (ceil(DEVICE_SECTORS/32) rows, at most 2048), and stalls items until
// the sweep ends. Magic loads, data beats that are not the last of a sector,
// non-matching last beats, out of range beats and rewinds pass through the
// back end without touching the mark store, so a beat stream runs at one
// item per cycle while results are not stalled. A matching last beat reads
// the sector's row and, if its bit is clear, writes it back with the bit set.
// A range request walks the mark rows from the scan position to the start
// and then the end of a run. Every item gives exactly one result; a
// four-entry queue decouples the beat compare from the mark store so a
// stalled result does not stop items from being taken until it fills.
`timescale 1ns / 1ps

module magic_sector_bitmap_collector #(
	parameter int DEVICE_SECTORS = msbc_pkg::DEVICE_SECTORS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  msbc_pkg::in_item_t           item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output msbc_pkg::out_item_t          result,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [msbc_pkg::CFG_W-1:0]   cfg_data
);

	localparam logic [31:0] DEV_V = 32'(DEVICE_SECTORS);

	logic [msbc_pkg::MAGIC_LEN_W-1:0] magic_len_q;
	logic [msbc_pkg::CAP_W-1:0]       capacity_q;
	logic [msbc_pkg::CAP_W-1:0]       cap;
	logic                             clearing;
	logic                             push;
	logic                             pop;
	msbc_pkg::q_entry_t               push_entry;
	msbc_pkg::q_entry_t               head;
	msbc_pkg::q_status_t              q_status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_len_q <= msbc_pkg::MAGIC_LEN_RST;
			capacity_q  <= msbc_pkg::CAPACITY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				msbc_pkg::CFG_MAGIC_LEN: magic_len_q <= cfg_data[msbc_pkg::MAGIC_LEN_W-1:0];
				msbc_pkg::CFG_CAPACITY:  capacity_q  <= cfg_data[msbc_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// effective capacity is limited by the device size
	assign cap = ({15'd0, capacity_q} > DEV_V) ? DEV_V[msbc_pkg::CAP_W-1:0] : capacity_q;

	msbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.magic_len  (magic_len_q),
		.cap        (cap),
		.clearing   (clearing),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	msbc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	msbc_back #(
		.DEVICE_SECTORS (DEVICE_SECTORS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cap          (cap),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
